// File: rtl/gzd_pkg.sv
// Shared constants, types and functions of the gzip member deframer.
package gzd_pkg;

   localparam int TRAILER_BYTES = 8;
   localparam int FILL_W        = $clog2(TRAILER_BYTES + 1);
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

   localparam logic [7:0]  MAGIC1_BYTE  = 8'h1f;
   localparam logic [7:0]  MAGIC2_BYTE  = 8'h8b;
   localparam logic [7:0]  METHOD_BYTE  = 8'h08;
   localparam logic [7:0]  FL_HCRC      = 8'h02;
   localparam logic [7:0]  FL_EXTRA     = 8'h04;
   localparam logic [7:0]  FL_NAME      = 8'h08;
   localparam logic [7:0]  FL_COMMENT   = 8'h10;
   localparam logic [7:0]  FL_RESERVED  = 8'he0;
   localparam logic [15:0] FIXED_BYTES  = 16'd6;
   localparam logic [31:0] CRC_POLY     = 32'hedb88320;
   localparam logic [31:0] CRC_INIT     = 32'hffffffff;
   localparam logic [31:0] MAX_SIZE_RST = 32'h10000000;

   localparam logic [3:0] PH_MAGIC1  = 4'd0;
   localparam logic [3:0] PH_MAGIC2  = 4'd1;
   localparam logic [3:0] PH_METHOD  = 4'd2;
   localparam logic [3:0] PH_FLAGS   = 4'd3;
   localparam logic [3:0] PH_FIXED   = 4'd4;
   localparam logic [3:0] PH_XLEN_LO = 4'd5;
   localparam logic [3:0] PH_XLEN_HI = 4'd6;
   localparam logic [3:0] PH_EXTRA   = 4'd7;
   localparam logic [3:0] PH_NAME    = 4'd8;
   localparam logic [3:0] PH_COMMENT = 4'd9;
   localparam logic [3:0] PH_HCRC_LO = 4'd10;
   localparam logic [3:0] PH_HCRC_HI = 4'd11;
   localparam logic [3:0] PH_PAYLOAD = 4'd12;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_LIMIT     = 2'd2;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   // Everything one accepted item causes: an optional payload byte and an optional report.
   typedef struct packed {
      logic        pay;
      logic [7:0]  data;
      logic        rep;
      logic [1:0]  status;
      logic [31:0] crc;
      logic [31:0] size;
   } evt_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      end
      return r;
   endfunction

   // First optional field after the given phase that the flags ask for.
   function automatic logic [3:0] next_field(input logic [3:0] after, input logic [7:0] flags);
      logic [3:0] ph;
      if (after < PH_XLEN_LO && (flags & FL_EXTRA) != 8'd0) begin
         ph = PH_XLEN_LO;
      end else if (after < PH_NAME && (flags & FL_NAME) != 8'd0) begin
         ph = PH_NAME;
      end else if (after < PH_COMMENT && (flags & FL_COMMENT) != 8'd0) begin
         ph = PH_COMMENT;
      end else if (after < PH_HCRC_LO && (flags & FL_HCRC) != 8'd0) begin
         ph = PH_HCRC_LO;
      end else begin
         ph = PH_PAYLOAD;
      end
      return ph;
   endfunction

endpackage

// File: rtl/gzd_ifs.sv
// Handshake interfaces of the input and result channels.
interface gzd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source(output valid, in_byte, in_last, input ready);
   modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface gzd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [1:0]  status;
   logic [31:0] expected_crc;
   logic [31:0] expected_size;
   modport source(output valid, kind, data_byte, status, expected_crc, expected_size,
                  input ready);
   modport sink(input valid, kind, data_byte, status, expected_crc, expected_size,
                output ready);
endinterface

// File: rtl/gzip_member_deframer.sv
// Top level of the gzip member deframer: front parser, item queue and result back end.
// Usage:
//   req_ch carries one byte of a gzip member per item (in_byte), in_last on the final byte.
//   rsp_ch carries result items: kind 0 is a deflate payload byte in data_byte, kind 1 is the
//   end-of-member report with status, expected_crc and expected_size.
//   csr_we/csr_wdata write max_output_size; write it only while no item is in flight.
// Timing:
//   The eight trailer bytes are held back, so a payload byte leaves eight input items later.
//   From acceptance, a result passes through the queue and then the output register to rsp_ch.
//   One input item per cycle is taken while the queue is not full; an item that yields both
//   a payload byte and the report gives two result items, payload byte first. The four-entry
//   queue between the parser and the output register absorbs short output stalls.
// Reset:
//   Synchronous reset clears the parser, the queue and the output valid, and sets
//   max_output_size to 0x10000000. After each report the parser starts a new member.
// Backpressure:
//   While rsp_ch.ready is low the output register holds its item; the queue fills and
//   req_ch.ready drops once it is full.
module gzip_member_deframer import gzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gzd_req_if.sink     req_ch,
   gzd_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   logic    q_push, q_full, q_pop, q_empty;
   evt_type q_evt, q_head;

   gzd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_evt     (q_evt)
   );

   gzd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_evt (q_evt),
      .full     (q_full),
      .pop      (q_pop),
      .head_evt (q_head),
      .empty    (q_empty)
   );

   gzd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_evt (q_head),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// File: rtl/gzd_front.sv
// Front part: trailer delay line, header parser, size limit register and item classification.
module gzd_front import gzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gzd_req_if.sink     req_ch,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        q_full,
   output logic        q_push,
   output evt_type     q_evt
);

   logic [7:0]        line_ff [TRAILER_BYTES];
   logic [7:0]        line_in [TRAILER_BYTES];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [3:0]        phase_ff, phase_in;
   logic [15:0]       count_ff, count_in;
   logic [7:0]        flags_ff, flags_in;
   logic [31:0]       hcrc_ff, hcrc_in;
   logic [7:0]        hcrc_low_ff, hcrc_low_in;
   logic              err_ff, err_in;
   logic [31:0]       max_size_ff;

   logic              accept;
   logic              line_full;
   logic              full_after;
   logic [7:0]        leaving;
   logic [15:0]       cnt_next;
   logic [31:0]       tr_crc, tr_size;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign line_full    = (fill_ff == FILL_W'(TRAILER_BYTES));
   assign leaving      = line_ff[0];

   always_comb begin
      for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
         line_in[i] = line_ff[i+1];
      end
      line_in[TRAILER_BYTES-1] = req_ch.in_byte;
      fill_in     = line_full ? fill_ff : fill_ff + FILL_W'(1);
      full_after  = (fill_in == FILL_W'(TRAILER_BYTES));
      phase_in    = phase_ff;
      count_in    = count_ff;
      flags_in    = flags_ff;
      hcrc_in     = hcrc_ff;
      hcrc_low_in = hcrc_low_ff;
      err_in      = err_ff;
      cnt_next    = 16'd0;
      q_evt       = '0;

      if (line_full && !err_ff) begin
         if (phase_ff < PH_HCRC_LO) begin
            hcrc_in = crc_byte(hcrc_ff, leaving);
         end
         case (phase_ff)
            PH_MAGIC1: begin
               if (leaving != MAGIC1_BYTE) err_in = 1'b1; else phase_in = PH_MAGIC2;
            end
            PH_MAGIC2: begin
               if (leaving != MAGIC2_BYTE) err_in = 1'b1; else phase_in = PH_METHOD;
            end
            PH_METHOD: begin
               if (leaving != METHOD_BYTE) err_in = 1'b1; else phase_in = PH_FLAGS;
            end
            PH_FLAGS: begin
               flags_in = leaving;
               if ((leaving & FL_RESERVED) != 8'd0) begin
                  err_in = 1'b1;
               end else begin
                  count_in = 16'd0;
                  phase_in = PH_FIXED;
               end
            end
            PH_FIXED: begin
               cnt_next = count_ff + 16'd1;
               count_in = cnt_next;
               if (cnt_next >= FIXED_BYTES) phase_in = next_field(PH_FIXED, flags_ff);
            end
            PH_XLEN_LO: begin
               count_in = {8'd0, leaving};
               phase_in = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
               cnt_next = {leaving, count_ff[7:0]};
               count_in = cnt_next;
               if (cnt_next == 16'd0) phase_in = next_field(PH_EXTRA, flags_ff);
               else phase_in = PH_EXTRA;
            end
            PH_EXTRA: begin
               cnt_next = count_ff - 16'd1;
               count_in = cnt_next;
               if (cnt_next == 16'd0) phase_in = next_field(PH_EXTRA, flags_ff);
            end
            PH_NAME: begin
               if (leaving == 8'd0) phase_in = next_field(PH_NAME, flags_ff);
            end
            PH_COMMENT: begin
               if (leaving == 8'd0) phase_in = next_field(PH_COMMENT, flags_ff);
            end
            PH_HCRC_LO: begin
               hcrc_low_in = leaving;
               phase_in    = PH_HCRC_HI;
            end
            PH_HCRC_HI: begin
               if (~hcrc_ff[15:0] != {leaving, hcrc_low_ff}) err_in = 1'b1;
               else phase_in = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               q_evt.pay  = 1'b1;
               q_evt.data = leaving;
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end

      tr_crc  = {line_in[3], line_in[2], line_in[1], line_in[0]};
      tr_size = {line_in[7], line_in[6], line_in[5], line_in[4]};

      if (req_ch.in_last) begin
         q_evt.rep = 1'b1;
         if (full_after) begin
            q_evt.crc  = tr_crc;
            q_evt.size = tr_size;
         end
         if (err_in || !full_after || phase_in != PH_PAYLOAD) begin
            q_evt.status = ST_MALFORMED;
         end else if (tr_size > max_size_ff) begin
            q_evt.status = ST_LIMIT;
         end else begin
            q_evt.status = ST_OK;
         end
         fill_in     = '0;
         phase_in    = PH_MAGIC1;
         count_in    = 16'd0;
         flags_in    = 8'd0;
         hcrc_in     = CRC_INIT;
         hcrc_low_in = 8'd0;
         err_in      = 1'b0;
      end
   end

   assign q_push = accept && (q_evt.pay || q_evt.rep);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_SIZE_RST;
      end else if (csr_we) begin
         max_size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < TRAILER_BYTES; i++) begin
            line_ff[i] <= line_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         phase_ff    <= PH_MAGIC1;
         count_ff    <= 16'd0;
         flags_ff    <= 8'd0;
         hcrc_ff     <= CRC_INIT;
         hcrc_low_ff <= 8'd0;
         err_ff      <= 1'b0;
      end else if (accept) begin
         fill_ff     <= fill_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         flags_ff    <= flags_in;
         hcrc_ff     <= hcrc_in;
         hcrc_low_ff <= hcrc_low_in;
         err_ff      <= err_in;
      end
   end

   a_pay_needs_full_line: assert property (@(posedge clock) disable iff (reset)
      q_push && q_evt.pay |-> line_full && !err_ff)
      else $error("payload item before trailer line filled");

   a_report_restarts: assert property (@(posedge clock) disable iff (reset)
      q_push && q_evt.rep |=> fill_ff == '0 && phase_ff == PH_MAGIC1 && !err_ff)
      else $error("member state not cleared after report");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TRAILER_BYTES))
      else $error("delay fill beyond trailer length");

endmodule

// File: rtl/gzd_queue.sv
// Short queue of classified items between front and back.
module gzd_queue import gzd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  evt_type push_evt,
   output logic    full,
   input  logic    pop,
   output evt_type head_evt,
   output logic    empty
);

   evt_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;

   assign full     = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_evt = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         if (push && !pop)      count_ff <= count_ff + (FIFO_AW+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (FIFO_AW+1)'(1);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("item pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("item popped from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("queue count beyond depth");

endmodule

// File: rtl/gzd_back.sv
// Back part: splits queued items into result items and holds them in the output register.
module gzd_back import gzd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  evt_type head_evt,
   input  logic    empty,
   output logic    pop,
   gzd_rsp_if.source rsp_ch
);

   logic        out_valid_ff, out_valid_in;
   logic        pay_done_ff, pay_done_in;
   logic        kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] size_ff, size_in;
   logic        load, take;

   assign load = !out_valid_ff || rsp_ch.ready;
   assign take = load && !empty;

   always_comb begin
      out_valid_in = load ? !empty : out_valid_ff;
      pay_done_in  = pay_done_ff;
      pop          = 1'b0;
      kind_in      = kind_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      crc_in       = crc_ff;
      size_in      = size_ff;
      if (take) begin
         if (head_evt.pay && !pay_done_ff) begin
            kind_in   = KIND_PAYLOAD;
            data_in   = head_evt.data;
            status_in = ST_OK;
            crc_in    = 32'd0;
            size_in   = 32'd0;
            if (head_evt.rep) pay_done_in = 1'b1;
            else pop = 1'b1;
         end else begin
            kind_in     = KIND_REPORT;
            data_in     = 8'd0;
            status_in   = head_evt.status;
            crc_in      = head_evt.crc;
            size_in     = head_evt.size;
            pop         = 1'b1;
            pay_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pay_done_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pay_done_ff  <= pay_done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      crc_ff    <= crc_in;
      size_ff   <= size_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.kind          = kind_ff;
   assign rsp_ch.data_byte     = data_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.expected_crc  = crc_ff;
   assign rsp_ch.expected_size = size_ff;

   a_split_holds_head: assert property (@(posedge clock) disable iff (reset)
      pay_done_ff |-> !empty && head_evt.rep)
      else $error("pending report lost its queue entry");

   a_split_order: assert property (@(posedge clock) disable iff (reset)
      pay_done_ff && take |-> kind_in == KIND_REPORT && pop)
      else $error("report not sent after its payload byte");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && kind_ff == KIND_PAYLOAD |-> status_ff == ST_OK && size_ff == 32'd0)
      else $error("payload result carries report fields");

endmodule

// File: bench/tb_gzip_member_deframer.sv
// Self-checking testbench of gzip_member_deframer: directed table, then random members.
module tb_gzip_member_deframer;
   import gzd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 950;
   localparam int DIR_ROWS     = 23;
   localparam int NUM_PHASES   = 6;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic [1:0]  status;
      logic [31:0] crc;
      logic [31:0] size;
   } deframe_result_type;

   typedef struct {
      logic [7:0]  b;
      bit          is_last;
      bit          typed;
      logic [1:0]  status;
      logic [31:0] crc;
      logic [31:0] size;
   } dir_row_type;

   typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_BURSTY} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;

   gzd_req_if req_ch();
   gzd_rsp_if rsp_ch();

   gzip_member_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow state of the deframer
   logic [7:0]  hold_line [TRAILER_BYTES];
   int unsigned hold_count;
   logic [3:0]  hdr_phase;
   logic [15:0] hdr_count;
   logic [7:0]  hdr_flags;
   logic [31:0] hdr_crc;
   logic [7:0]  hcrc_low;
   bit          hdr_bad;
   logic [31:0] size_limit;

   deframe_result_type pending_results[$];
   logic [7:0]         member_bytes[$];
   int unsigned        fail_count;
   int unsigned        items_sent;
   int unsigned        burst_left;
   int unsigned        quiet_cycles;
   rx_mode_type        rx_mode;
   int unsigned        rx_mode_left;
   int unsigned        rx_hold;
   bit                 rx_low;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{8'hff, 1'b1, 1'b1, ST_MALFORMED, 32'h0, 32'h0},
      '{8'h1f, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h8b, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h08, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'hff, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'hff, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'hff, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'hff, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h78, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h56, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h34, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h12, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'hff, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'hff, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'hff, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'hff, 1'b1, 1'b1, ST_LIMIT, 32'h12345678, 32'hffffffff},
      '{8'h00, 1'b0, 1'b0, ST_OK, 32'h0, 32'h0},
      '{8'h8b, 1'b1, 1'b1, ST_MALFORMED, 32'h0, 32'h0}
   };

   function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [3:0] after_field(input logic [3:0] done);
      if (done < PH_XLEN_LO && (hdr_flags & FL_EXTRA) != 8'd0) begin
         return PH_XLEN_LO;
      end else if (done < PH_NAME && (hdr_flags & FL_NAME) != 8'd0) begin
         return PH_NAME;
      end else if (done < PH_COMMENT && (hdr_flags & FL_COMMENT) != 8'd0) begin
         return PH_COMMENT;
      end else if (done < PH_HCRC_LO && (hdr_flags & FL_HCRC) != 8'd0) begin
         return PH_HCRC_LO;
      end
      return PH_PAYLOAD;
   endfunction

   function automatic void clear_member();
      for (int i = 0; i < TRAILER_BYTES; i++) begin
         hold_line[i] = 8'd0;
      end
      hold_count = 0;
      hdr_phase  = PH_MAGIC1;
      hdr_count  = 16'd0;
      hdr_flags  = 8'd0;
      hdr_crc    = CRC_INIT;
      hcrc_low   = 8'd0;
      hdr_bad    = 1'b0;
   endfunction

   // returns 1 when the byte is deflate payload
   function automatic bit parse_header_byte(input logic [7:0] b);
      logic [15:0] stored;
      bit          is_pay;
      is_pay = 1'b0;
      if (hdr_phase < PH_HCRC_LO) begin
         hdr_crc = crc32_byte(hdr_crc, b);
      end
      case (hdr_phase)
         PH_MAGIC1: begin
            if (b != MAGIC1_BYTE) hdr_bad = 1'b1;
            else hdr_phase = PH_MAGIC2;
         end
         PH_MAGIC2: begin
            if (b != MAGIC2_BYTE) hdr_bad = 1'b1;
            else hdr_phase = PH_METHOD;
         end
         PH_METHOD: begin
            if (b != METHOD_BYTE) hdr_bad = 1'b1;
            else hdr_phase = PH_FLAGS;
         end
         PH_FLAGS: begin
            hdr_flags = b;
            if ((b & FL_RESERVED) != 8'd0) begin
               hdr_bad = 1'b1;
            end else begin
               hdr_count = 16'd0;
               hdr_phase = PH_FIXED;
            end
         end
         PH_FIXED: begin
            hdr_count = hdr_count + 16'd1;
            if (hdr_count >= FIXED_BYTES) hdr_phase = after_field(PH_FIXED);
         end
         PH_XLEN_LO: begin
            hdr_count = {8'd0, b};
            hdr_phase = PH_XLEN_HI;
         end
         PH_XLEN_HI: begin
            hdr_count = hdr_count | {b, 8'd0};
            if (hdr_count == 16'd0) hdr_phase = after_field(PH_EXTRA);
            else hdr_phase = PH_EXTRA;
         end
         PH_EXTRA: begin
            hdr_count = hdr_count - 16'd1;
            if (hdr_count == 16'd0) hdr_phase = after_field(PH_EXTRA);
         end
         PH_NAME: begin
            if (b == 8'd0) hdr_phase = after_field(PH_NAME);
         end
         PH_COMMENT: begin
            if (b == 8'd0) hdr_phase = after_field(PH_COMMENT);
         end
         PH_HCRC_LO: begin
            hcrc_low  = b;
            hdr_phase = PH_HCRC_HI;
         end
         PH_HCRC_HI: begin
            stored = {b, hcrc_low};
            if (~hdr_crc[15:0] != stored) hdr_bad = 1'b1;
            else hdr_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            is_pay = 1'b1;
         end
         default: begin
            hdr_bad = 1'b1;
         end
      endcase
      return is_pay;
   endfunction

   function automatic void advance_deframer(input logic [7:0] b, input bit is_last);
      logic [7:0]         leaving;
      deframe_result_type res;
      if (hold_count < TRAILER_BYTES) begin
         hold_line[hold_count] = b;
         hold_count++;
      end else begin
         leaving = hold_line[0];
         for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
            hold_line[i] = hold_line[i+1];
         end
         hold_line[TRAILER_BYTES-1] = b;
         if (!hdr_bad && parse_header_byte(leaving) && !hdr_bad) begin
            res = '{KIND_PAYLOAD, leaving, ST_OK, 32'd0, 32'd0};
            pending_results.push_back(res);
         end
      end
      if (is_last) begin
         res = '{KIND_REPORT, 8'd0, ST_OK, 32'd0, 32'd0};
         if (hold_count >= TRAILER_BYTES) begin
            res.crc  = {hold_line[3], hold_line[2], hold_line[1], hold_line[0]};
            res.size = {hold_line[7], hold_line[6], hold_line[5], hold_line[4]};
         end
         if (hdr_bad || hold_count < TRAILER_BYTES || hdr_phase != PH_PAYLOAD) begin
            res.status = ST_MALFORMED;
         end else if (res.size > size_limit) begin
            res.status = ST_LIMIT;
         end
         pending_results.push_back(res);
         clear_member();
      end
   endfunction

   // one gzip member, mostly well formed, sometimes damaged or plain noise
   function automatic void build_member();
      logic [7:0]  flg;
      logic [31:0] crc;
      logic [31:0] isize;
      int unsigned xlen;
      int unsigned hdr_len;
      int unsigned roll;
      member_bytes.delete();
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 12)) member_bytes.push_back(8'($urandom));
         return;
      end
      flg = 8'($urandom) & (FL_HCRC | FL_EXTRA | FL_NAME | FL_COMMENT | 8'h01);
      member_bytes.push_back(MAGIC1_BYTE);
      member_bytes.push_back(MAGIC2_BYTE);
      member_bytes.push_back(METHOD_BYTE);
      member_bytes.push_back(flg);
      repeat (6) member_bytes.push_back(8'($urandom));
      if ((flg & FL_EXTRA) != 8'd0) begin
         xlen = ($urandom_range(0, 30) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
         member_bytes.push_back(xlen[7:0]);
         member_bytes.push_back(xlen[15:8]);
         repeat (xlen) member_bytes.push_back(8'($urandom));
      end
      if ((flg & FL_NAME) != 8'd0) begin
         repeat ($urandom_range(0, 6)) member_bytes.push_back(8'($urandom_range(1, 255)));
         member_bytes.push_back(8'd0);
      end
      if ((flg & FL_COMMENT) != 8'd0) begin
         repeat ($urandom_range(0, 6)) member_bytes.push_back(8'($urandom_range(1, 255)));
         member_bytes.push_back(8'd0);
      end
      if ((flg & FL_HCRC) != 8'd0) begin
         crc = CRC_INIT;
         foreach (member_bytes[i]) crc = crc32_byte(crc, member_bytes[i]);
         crc = ~crc;
         if ($urandom_range(0, 9) == 0) crc[$urandom_range(0, 15)] ^= 1'b1;
         member_bytes.push_back(crc[7:0]);
         member_bytes.push_back(crc[15:8]);
      end
      hdr_len = member_bytes.size();
      if ($urandom_range(0, 15) == 0) begin
         repeat ($urandom_range(60, 120)) member_bytes.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(0, 24)) member_bytes.push_back(8'($urandom));
      end
      crc = $urandom;
      case ($urandom_range(0, 5))
         0: isize = size_limit;
         1: isize = size_limit + 32'd1;
         2: isize = 32'd0;
         3: isize = 32'hffffffff;
         4: isize = $urandom;
         default: isize = $urandom_range(0, 5000);
      endcase
      for (int i = 0; i < 4; i++) member_bytes.push_back(crc[8*i +: 8]);
      for (int i = 0; i < 4; i++) member_bytes.push_back(isize[8*i +: 8]);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         member_bytes[$urandom_range(0, hdr_len - 1)] ^= 8'($urandom_range(1, 255));
      end else if (roll < 16) begin
         member_bytes[3] = member_bytes[3] | (8'h20 << $urandom_range(0, 2));
      end else if (roll < 22) begin
         member_bytes = member_bytes[0:$urandom_range(0, member_bytes.size() - 2)];
      end
   endfunction

   function automatic void flag_fault(input string why, input deframe_result_type want,
                                      input deframe_result_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t %s: got kind %0d data %02h status %0d crc %08h size %08h", $realtime,
                  why, got.kind, got.data, got.status, got.crc, got.size);
         $display("   expected kind %0d data %02h status %0d crc %08h size %08h",
                  want.kind, want.data, want.status, want.crc, want.size);
      end
   endfunction

   // drive one item and wait for its accepting edge
   task automatic push_byte(input logic [7:0] b, input bit is_last);
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      advance_deframer(b, is_last);
      items_sent++;
   endtask

   // burst and gap pacing of the sender
   task automatic pace();
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         if ($urandom_range(0, 40) == 0) begin
            while (pending_results.size() != 0) @(posedge clock);
         end
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit is_last);
      push_byte(b, is_last);
      pace();
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size_limit(input logic [31:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we     <= 1'b0;
      size_limit = v;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result checker
   always @(posedge clock) begin
      deframe_result_type got;
      deframe_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.kind, rsp_ch.data_byte, rsp_ch.status, rsp_ch.expected_crc,
                 rsp_ch.expected_size};
         if (pending_results.size() == 0) begin
            flag_fault("unexpected item", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.data !== want.data ||
                got.status !== want.status || got.crc !== want.crc ||
                got.size !== want.size) begin
               flag_fault("mismatch", want, got);
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 2));
         rx_mode_left = $urandom_range(50, 300);
      end else begin
         rx_mode_left--;
      end
      case (rx_mode)
         RX_FREE: begin
            rsp_ch.ready <= 1'b1;
         end
         RX_COIN: begin
            rsp_ch.ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            if (rx_hold == 0) begin
               rx_hold = $urandom_range(1, 15);
               rx_low  = !rx_low;
            end else begin
               rx_hold--;
            end
            rsp_ch.ready <= !rx_low;
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [31:0]        phase_limit [NUM_PHASES];
      deframe_result_type typed_res;
      int unsigned        goal;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = 32'd0;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'd0;
      req_ch.in_last = 1'b0;
      rsp_ch.ready   = 1'b0;
      fail_count     = 0;
      items_sent     = 0;
      burst_left     = 0;
      quiet_cycles   = 0;
      rx_mode        = RX_FREE;
      rx_mode_left   = 0;
      rx_hold        = 0;
      rx_low         = 1'b0;
      size_limit     = MAX_SIZE_RST;
      clear_member();
      phase_limit = '{32'hffffffff, 32'h0, $urandom, 32'h00000100, MAX_SIZE_RST,
                      $urandom_range(0, 5000)};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         push_byte(dir_rows[i].b, dir_rows[i].is_last);
         if (dir_rows[i].typed) begin
            typed_res        = pending_results.pop_back();
            typed_res.status = dir_rows[i].status;
            typed_res.crc    = dir_rows[i].crc;
            typed_res.size   = dir_rows[i].size;
            pending_results.push_back(typed_res);
         end
         pace();
      end

      items_sent = 0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_size_limit(phase_limit[p]);
         goal = (p + 1) * RANDOM_ITEMS / NUM_PHASES;
         while (items_sent < goal) begin
            build_member();
            foreach (member_bytes[i]) begin
               send_byte(member_bytes[i], i == member_bytes.size() - 1);
            end
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: gzip_member_deframer.f
rtl/gzd_pkg.sv
rtl/gzd_ifs.sv
rtl/gzd_front.sv
rtl/gzd_queue.sv
rtl/gzd_back.sv
rtl/gzip_member_deframer.sv
bench/tb_gzip_member_deframer.sv
